// ===== rtl/tari_pkg.sv =====
package tari_pkg;

   localparam int COORD_W   = 32;
   localparam int NUM_COORD = 12;
   localparam int IN_W      = COORD_W * NUM_COORD;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int MAG_W     = PROD_W;
   localparam int HALF_W    = MAG_W / 2;
   localparam int PP_W      = 2 * HALF_W;
   localparam int SQ_W      = 2 * MAG_W + 2;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int REM_W     = ROOT_W + 3;
   localparam int DREM_W    = ROOT_W + 1;
   localparam int FRAC_BITS = 16;
   localparam int RATIO_W   = FRAC_BITS + 1;
   localparam int SUM_W     = RATIO_W + 2;
   localparam int TOL_W     = 16;
   localparam int OUT_W     = 56;
   localparam int NUM_EDGE  = 5;
   localparam int NUM_CROSS = 4;
   localparam int FRONT_DEPTH = 6;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + ROOT_W + RATIO_W + 1;

   localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(64);
   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

   // csr register indexes
   localparam logic REG_SUM_TOLERANCE = 1'b0;

   // edge vectors: e01, e02, e0p, ep1, ep2
   localparam int EDGE_01 = 0;
   localparam int EDGE_02 = 1;
   localparam int EDGE_0P = 2;
   localparam int EDGE_P1 = 3;
   localparam int EDGE_P2 = 4;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [PP_W-1:0]          pp_type;
   typedef logic [SQ_W-1:0]          sq_type;
   typedef logic [ROOT_W-1:0]        root_type;
   typedef logic [RATIO_W-1:0]       ratio_type;

   typedef struct packed {
      ratio_type quo;
      logic      sat;
      logic      den_zero;
   } div_res_type;

   // operand edges of each cross product: whole, edge01, edge02, edge12
   function automatic int cross_a(input int c);
      unique case (c)
         0:       return EDGE_01;
         1:       return EDGE_01;
         2:       return EDGE_0P;
         default: return EDGE_P1;
      endcase
   endfunction

   function automatic int cross_b(input int c);
      unique case (c)
         0:       return EDGE_02;
         1:       return EDGE_0P;
         2:       return EDGE_02;
         default: return EDGE_P2;
      endcase
   endfunction

endpackage

// ===== rtl/tari_isqrt.sv =====
module tari_isqrt (
   input  logic                 clock,
   input  logic                 adv,
   input  tari_pkg::sq_type     radicand,
   output tari_pkg::root_type   root
);

   logic [tari_pkg::REM_W-1:0] rem_ff  [tari_pkg::ROOT_W-1];
   tari_pkg::sq_type           rad_ff  [tari_pkg::ROOT_W-1];
   tari_pkg::root_type         root_ff [tari_pkg::ROOT_W];

   genvar s;
   for (s = 0; s < tari_pkg::ROOT_W; s++) begin : g_step
      logic [tari_pkg::REM_W-1:0] rem_prev;
      logic [tari_pkg::REM_W-1:0] cur;
      logic [tari_pkg::REM_W-1:0] trial;
      logic [tari_pkg::REM_W-1:0] rem_in;
      tari_pkg::root_type         root_prev;
      tari_pkg::root_type         root_in;
      tari_pkg::sq_type           rad_prev;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         cur   = {rem_prev[tari_pkg::REM_W-3:0], rad_prev[tari_pkg::SQ_W-1 -: 2]};
         trial = {{(tari_pkg::REM_W-tari_pkg::ROOT_W-2){1'b0}}, root_prev, 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_prev[tari_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_prev[tari_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[s] <= root_in;
         end
      end

      if (s < tari_pkg::ROOT_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= rem_in;
               rad_ff[s] <= {rad_prev[tari_pkg::SQ_W-3:0], 2'b00};
            end
         end
      end
   end

   assign root = root_ff[tari_pkg::ROOT_W-1];

endmodule

// ===== rtl/tari_div.sv =====
module tari_div (
   input  logic                  clock,
   input  logic                  adv,
   input  tari_pkg::root_type    num,
   input  tari_pkg::root_type    den,
   output tari_pkg::div_res_type res
);

   logic [tari_pkg::DREM_W-1:0] rem_ff [tari_pkg::RATIO_W-1];
   tari_pkg::root_type          den_ff [tari_pkg::RATIO_W];
   tari_pkg::ratio_type         q_ff   [tari_pkg::RATIO_W];
   logic                        sat_ff [tari_pkg::RATIO_W];

   genvar j;
   for (j = 0; j < tari_pkg::RATIO_W; j++) begin : g_bit
      logic [tari_pkg::DREM_W-1:0] rem_prev;
      logic [tari_pkg::DREM_W-1:0] den_ext;
      logic [tari_pkg::DREM_W-1:0] diff;
      tari_pkg::root_type          den_prev;
      tari_pkg::ratio_type         q_prev;
      logic                        sat_prev;
      logic                        qbit;

      if (j == 0) begin : g_first
         assign rem_prev = {1'b0, num};
         assign den_prev = den;
         assign q_prev   = '0;
         // quotient would need more than RATIO_W bits
         assign sat_prev = ({1'b0, num} >= {den, 1'b0});
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign sat_prev = sat_ff[j-1];
      end

      always_comb begin
         den_ext = {1'b0, den_prev};
         if (rem_prev >= den_ext) begin
            diff = rem_prev - den_ext;
            qbit = 1'b1;
         end else begin
            diff = rem_prev;
            qbit = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[j] <= den_prev;
            q_ff[j]   <= {q_prev[tari_pkg::RATIO_W-2:0], qbit};
            sat_ff[j] <= sat_prev;
         end
      end

      if (j < tari_pkg::RATIO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j] <= {diff[tari_pkg::DREM_W-2:0], 1'b0};
            end
         end
      end
   end

   assign res.quo      = q_ff[tari_pkg::RATIO_W-1];
   assign res.sat      = sat_ff[tari_pkg::RATIO_W-1];
   assign res.den_zero = (den_ff[tari_pkg::RATIO_W-1] == '0);

endmodule

// ===== rtl/triangle_area_ratio_inside_test.sv =====
// Point-in-triangle test in 3D by area ratios.
// req_ channel: one item per handshake, twelve signed Q16.16 coordinates
// (vertex 0, 1, 2 then the query point, x y z each). rsp_ channel: one item
// per request with three Q1.16 area ratios, the inside flag and the
// degenerate flag. csr_ port: sum_tolerance at byte address 0 (Q0.16).
// From request accept to response valid an item passes the edge vectors,
// cross products and squared lengths, the integer square root at one root
// bit per stage, the division at one quotient bit per stage, and the
// output register.
// Throughput is one item per cycle unless the output stalls. The pipeline
// moves as a whole: while rsp_tvalid is high and rsp_tready low every stage
// holds and req_tready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and loads sum_tolerance with 64.
// Write sum_tolerance only while no item is in flight.
module triangle_area_ratio_inside_test (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z, point_x, point_y, point_z
   input  logic [tari_pkg::IN_W-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // ratio_edge01, ratio_edge02, ratio_edge12, inside_res, degenerate, zeros
   output logic [tari_pkg::OUT_W-1:0]     rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   logic                       adv;
   logic                       vld_ff [tari_pkg::PIPE_DEPTH];
   logic [tari_pkg::TOL_W-1:0] tol_ff;

   tari_pkg::diff_type e_ff  [tari_pkg::NUM_EDGE][3];
   tari_pkg::prod_type pa_ff [tari_pkg::NUM_CROSS][3];
   tari_pkg::prod_type pb_ff [tari_pkg::NUM_CROSS][3];
   tari_pkg::mag_type  mag_ff[tari_pkg::NUM_CROSS][3];
   tari_pkg::pp_type   hh_ff [tari_pkg::NUM_CROSS][3];
   tari_pkg::pp_type   hl_ff [tari_pkg::NUM_CROSS][3];
   tari_pkg::pp_type   ll_ff [tari_pkg::NUM_CROSS][3];
   tari_pkg::sq_type   sq_ff [tari_pkg::NUM_CROSS][3];
   tari_pkg::sq_type   len2_ff [tari_pkg::NUM_CROSS];

   tari_pkg::root_type    root [tari_pkg::NUM_CROSS];
   tari_pkg::div_res_type dres [3];

   tari_pkg::ratio_type r_in  [3];
   tari_pkg::ratio_type r_ff  [3];
   logic                inside_in, inside_ff;
   logic                degen_in, degen_ff;

   // ---- csr ----
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tari_pkg::TOL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == tari_pkg::REG_SUM_TOLERANCE)) begin
         tol_ff <= csr_pwdata[tari_pkg::TOL_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == tari_pkg::REG_SUM_TOLERANCE) begin
         csr_prdata = {{(32-tari_pkg::TOL_W){1'b0}}, tol_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // ---- flow control: whole pipe advances unless the output is stuck ----
   assign adv        = !vld_ff[tari_pkg::PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[tari_pkg::PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tari_pkg::PIPE_DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < tari_pkg::PIPE_DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // ---- stage 1: edge vectors ----
   function automatic tari_pkg::diff_type sub_coord(input logic [31:0] a, input logic [31:0] b);
      return $signed({a[31], a}) - $signed({b[31], b});
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            e_ff[tari_pkg::EDGE_01][k] <= sub_coord(req_tdata[32*(3+k) +: 32],
                                                    req_tdata[32*k +: 32]);
            e_ff[tari_pkg::EDGE_02][k] <= sub_coord(req_tdata[32*(6+k) +: 32],
                                                    req_tdata[32*k +: 32]);
            e_ff[tari_pkg::EDGE_0P][k] <= sub_coord(req_tdata[32*(9+k) +: 32],
                                                    req_tdata[32*k +: 32]);
            e_ff[tari_pkg::EDGE_P1][k] <= sub_coord(req_tdata[32*(3+k) +: 32],
                                                    req_tdata[32*(9+k) +: 32]);
            e_ff[tari_pkg::EDGE_P2][k] <= sub_coord(req_tdata[32*(6+k) +: 32],
                                                    req_tdata[32*(9+k) +: 32]);
         end
      end
   end

   // ---- stages 2 to 6: cross products and squared lengths ----
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < tari_pkg::NUM_CROSS; c++) begin
            for (int k = 0; k < 3; k++) begin
               logic signed [tari_pkg::PROD_W:0] d;
               logic [tari_pkg::PROD_W:0]        m;
               // stage 2
               pa_ff[c][k] <= e_ff[tari_pkg::cross_a(c)][(k+1)%3]
                            * e_ff[tari_pkg::cross_b(c)][(k+2)%3];
               pb_ff[c][k] <= e_ff[tari_pkg::cross_a(c)][(k+2)%3]
                            * e_ff[tari_pkg::cross_b(c)][(k+1)%3];
               // stage 3: component magnitude
               d = {pa_ff[c][k][tari_pkg::PROD_W-1], pa_ff[c][k]}
                 - {pb_ff[c][k][tari_pkg::PROD_W-1], pb_ff[c][k]};
               m = d[tari_pkg::PROD_W] ? -d : d;
               mag_ff[c][k] <= m[tari_pkg::MAG_W-1:0];
               // stage 4: partial squares of the halves
               hh_ff[c][k] <= mag_ff[c][k][tari_pkg::MAG_W-1:tari_pkg::HALF_W]
                            * mag_ff[c][k][tari_pkg::MAG_W-1:tari_pkg::HALF_W];
               hl_ff[c][k] <= mag_ff[c][k][tari_pkg::MAG_W-1:tari_pkg::HALF_W]
                            * mag_ff[c][k][tari_pkg::HALF_W-1:0];
               ll_ff[c][k] <= mag_ff[c][k][tari_pkg::HALF_W-1:0]
                            * mag_ff[c][k][tari_pkg::HALF_W-1:0];
               // stage 5: assemble the square
               sq_ff[c][k] <= (tari_pkg::SQ_W'(hh_ff[c][k]) << (2*tari_pkg::HALF_W))
                            + (tari_pkg::SQ_W'(hl_ff[c][k]) << (tari_pkg::HALF_W+1))
                            + tari_pkg::SQ_W'(ll_ff[c][k]);
            end
            // stage 6
            len2_ff[c] <= sq_ff[c][0] + sq_ff[c][1] + sq_ff[c][2];
         end
      end
   end

   // ---- square roots, then ratios against the whole triangle ----
   genvar g;
   for (g = 0; g < tari_pkg::NUM_CROSS; g++) begin : g_sqrt
      tari_isqrt u_isqrt (
         .clock    (clock),
         .adv      (adv),
         .radicand (len2_ff[g]),
         .root     (root[g])
      );
   end

   for (g = 0; g < 3; g++) begin : g_div
      tari_div u_div (
         .clock (clock),
         .adv   (adv),
         .num   (root[g+1]),
         .den   (root[0]),
         .res   (dres[g])
      );
   end

   // ---- output stage ----
   always_comb begin
      logic [tari_pkg::SUM_W-1:0] sum;
      logic [tari_pkg::SUM_W-1:0] limit;
      logic                       bad;
      bad   = 1'b0;
      sum   = '0;
      limit = tari_pkg::SUM_W'(tari_pkg::RATIO_ONE) + tari_pkg::SUM_W'(tol_ff);
      for (int k = 0; k < 3; k++) begin
         r_in[k] = dres[k].sat ? tari_pkg::RATIO_MAX : dres[k].quo;
         bad     = bad || dres[k].sat || (dres[k].quo > tari_pkg::RATIO_ONE);
         sum     = sum + tari_pkg::SUM_W'(r_in[k]);
      end
      degen_in  = dres[0].den_zero;
      inside_in = !bad && (sum <= limit);
      if (degen_in) begin
         for (int k = 0; k < 3; k++) r_in[k] = '0;
         inside_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) r_ff[k] <= r_in[k];
         inside_ff <= inside_in;
         degen_ff  <= degen_in;
      end
   end

   assign rsp_tdata = {{(tari_pkg::OUT_W - 3*tari_pkg::RATIO_W - 2){1'b0}},
                       degen_ff, inside_ff, r_ff[2], r_ff[1], r_ff[0]};

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CLK_HALF    = 10;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  SETTLE      = 120;
   localparam int  NUM_RANDOM  = 1800;

   typedef logic signed [71:0] wide_type;
   typedef wide_type           vec_type [3];
   typedef logic [143:0]       big_type;
   typedef logic [31:0]        coord_set_type [tari_pkg::NUM_COORD];

   typedef struct packed {
      tari_pkg::ratio_type r01;
      tari_pkg::ratio_type r02;
      tari_pkg::ratio_type r12;
      logic                in_tri;
      logic                degen;
   } area_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tari_pkg::IN_W-1:0]     req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [tari_pkg::OUT_W-1:0]    rsp_tdata;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [2:0]                    csr_paddr = '0;
   logic [31:0]                   csr_pwdata = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   area_result_type               area_results_due [$];
   logic [tari_pkg::TOL_W-1:0]    tolerance_shadow = tari_pkg::TOL_RESET;
   int                            errors = 0;
   int                            cycles = 0;
   int                            send_idle_pct = 0;
   int                            recv_stall_pct = 0;
   int                            holdoff_left = 0;

   triangle_area_ratio_inside_test dut (.*);

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------- predictor ----------------
   function automatic big_type cross_length(input vec_type a, input vec_type b);
      big_type  acc;
      big_type  mag;
      big_type  root;
      big_type  trial;
      wide_type comp;
      int       i1;
      int       i2;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         i1 = (k + 1) % 3;
         i2 = (k + 2) % 3;
         comp = a[i1] * b[i2] - a[i2] * b[i1];
         if (comp < 0) comp = -comp;
         mag = comp;
         acc = acc + mag * mag;
      end
      root = '0;
      for (int i = 69; i >= 0; i--) begin
         trial = root | (big_type'(1) << i);
         if (trial * trial <= acc) root = trial;
      end
      return root;
   endfunction

   function automatic area_result_type predict_area(input coord_set_type c,
                                                    input logic [tari_pkg::TOL_W-1:0] tol);
      area_result_type     res;
      wide_type            v [4][3];
      vec_type             e01, e02, e0p, ep1, ep2;
      big_type             whole;
      big_type             part [3];
      logic [159:0]        quo;
      tari_pkg::ratio_type q [3];
      logic [19:0]         total;
      for (int n = 0; n < 4; n++)
         for (int k = 0; k < 3; k++)
            v[n][k] = wide_type'($signed(c[3*n+k]));
      for (int k = 0; k < 3; k++) begin
         e01[k] = v[1][k] - v[0][k];
         e02[k] = v[2][k] - v[0][k];
         e0p[k] = v[3][k] - v[0][k];
         ep1[k] = v[1][k] - v[3][k];
         ep2[k] = v[2][k] - v[3][k];
      end
      whole   = cross_length(e01, e02);
      part[0] = cross_length(e01, e0p);
      part[1] = cross_length(e0p, e02);
      part[2] = cross_length(ep1, ep2);
      res = '0;
      if (whole == 0) begin
         res.degen = 1'b1;
         return res;
      end
      res.in_tri = 1'b1;
      total = '0;
      for (int k = 0; k < 3; k++) begin
         quo = ({16'b0, part[k]} << tari_pkg::FRAC_BITS) / whole;
         if (quo >= (160'(1) << tari_pkg::RATIO_W)) begin
            q[k] = tari_pkg::RATIO_MAX;
            res.in_tri = 1'b0;
         end else begin
            q[k] = quo[tari_pkg::RATIO_W-1:0];
            if (q[k] > tari_pkg::RATIO_ONE) res.in_tri = 1'b0;
         end
         total = total + q[k];
      end
      if (total > 20'(tari_pkg::RATIO_ONE) + 20'(tol)) res.in_tri = 1'b0;
      res.r01 = q[0];
      res.r02 = q[1];
      res.r12 = q[2];
      return res;
   endfunction

   // ---------------- result checker ----------------
   always @(negedge clock) begin
      area_result_type want;
      area_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.r01    = rsp_tdata[tari_pkg::RATIO_W-1:0];
         got.r02    = rsp_tdata[2*tari_pkg::RATIO_W-1:tari_pkg::RATIO_W];
         got.r12    = rsp_tdata[3*tari_pkg::RATIO_W-1:2*tari_pkg::RATIO_W];
         got.in_tri = rsp_tdata[3*tari_pkg::RATIO_W];
         got.degen  = rsp_tdata[3*tari_pkg::RATIO_W+1];
         if (area_results_due.size() == 0) begin
            $display("%0t: unexpected item, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = area_results_due.pop_front();
            if (got != want
                || rsp_tdata[tari_pkg::OUT_W-1:3*tari_pkg::RATIO_W+2] != '0) begin
               $display("%0t: mismatch expected r01=%h r02=%h r12=%h in=%b dg=%b",
                        $time, want.r01, want.r02, want.r12, want.in_tri, want.degen);
               $display("%0t:          actual   r01=%h r02=%h r12=%h in=%b dg=%b pad=%h",
                        $time, got.r01, got.r02, got.r12, got.in_tri, got.degen,
                        rsp_tdata[tari_pkg::OUT_W-1:3*tari_pkg::RATIO_W+2]);
               errors++;
            end
         end
      end
   end

   // ---------------- drivers ----------------
   task automatic send_item(input coord_set_type c);
      area_result_type res;
      int              gap;
      res = predict_area(c, tolerance_shadow);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      for (int i = 0; i < tari_pkg::NUM_COORD; i++) req_tdata[32*i +: 32] <= c[i];
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      area_results_due.push_back(res);
   endtask

   task automatic send_tri(input longint a0, a1, a2, b0, b1, b2,
                           input longint d0, d1, d2, p0, p1, p2);
      coord_set_type c;
      c = '{32'(a0), 32'(a1), 32'(a2), 32'(b0), 32'(b1), 32'(b2),
            32'(d0), 32'(d1), 32'(d2), 32'(p0), 32'(p1), 32'(p2)};
      send_item(c);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (area_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [tari_pkg::TOL_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * tari_pkg::REG_SUM_TOLERANCE);
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tolerance_shadow = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      // read back
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata != 32'(value)) begin
         $display("%0t: tolerance readback expected %h actual %h",
                  $time, value, csr_prdata);
         errors++;
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------- tests ----------------
   task automatic test_directed();
      longint mx, mn;
      mx = 64'sh7FFFFFFF;
      mn = -64'sh80000000;
      send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                 // all zero
      send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 16384, 16384, 0); // within
      send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 0);         // at a vertex
      send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 32768, 32768, 0); // on an edge
      send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 65536, 0); // outside
      send_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 21845, 21845, 9999); // off plane
      send_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 5, 5, 5);                 // collinear
      send_tri(7, 7, 7, 7, 7, 7, 1, 2, 3, 4, 4, 4);                 // repeated vertex
      send_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, 0, 0, 0);
      send_tri(mx, mx, mx, mn, mn, mx, mx, mn, mn, mn, mn, mn);
      send_tri(mn, mx, mn, mx, mn, mx, mx, mx, mn, mx, mx, mx);
      send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, mx, mx, mx);             // huge ratios
      send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, mn, mn, mn);
      send_tri(mn, 0, 0, mx, 0, 0, 0, mx, mn, mn, mx, mx);
      send_tri(0, 0, 0, mx, 0, 0, 0, mx, 0, 1, 1, 0);
      send_tri(-1, -1, -1, 65536, 0, 0, 0, 65536, 0, 21845, 21846, 0);
   endtask

   task automatic random_item();
      coord_set_type c;
      longint        v [3][3];
      longint        a, b, rng;
      int            mode;
      mode = $urandom_range(9);
      rng  = (mode < 3) ? 64'd1 << 20 : 64'd1 << 12;
      for (int n = 0; n < 3; n++)
         for (int k = 0; k < 3; k++)
            v[n][k] = longint'($urandom_range(2 * rng)) - rng;
      a = $urandom_range(65536);
      b = $urandom_range(65536 - a + ((mode == 4) ? 300 : 0));
      if (mode == 6)          // collinear
         for (int k = 0; k < 3; k++) v[2][k] = v[0][k] + 3 * (v[1][k] - v[0][k]);
      for (int n = 0; n < 3; n++)
         for (int k = 0; k < 3; k++) c[3*n+k] = 32'(v[n][k]);
      for (int k = 0; k < 3; k++)
         c[9+k] = 32'(v[0][k] + (a * (v[1][k] - v[0][k]) + b * (v[2][k] - v[0][k])) / 65536);
      case (mode)
         5: for (int i = 0; i < tari_pkg::NUM_COORD; i++) c[i] = $urandom;
         7: for (int i = 9; i < tari_pkg::NUM_COORD; i++) c[i] = $urandom;
         8: for (int k = 0; k < 3; k++) c[9+k] = c[3*$urandom_range(2)+k];
         9: c[11] = c[11] + 32'($urandom_range(64)) - 32;
         default: ;
      endcase
      send_item(c);
   endtask

   task automatic test_random_phases();
      int                         idle [4];
      int                         stall [4];
      logic [tari_pkg::TOL_W-1:0] tol [4];
      idle  = '{0, 83, 0, 7};
      stall = '{0, 0, 83, 7};
      tol   = '{16'h0000, 16'hFFFF, 16'($urandom), tari_pkg::TOL_RESET};
      for (int ph = 0; ph < 4; ph++) begin
         write_tolerance(tol[ph]);
         send_idle_pct  = idle[ph];
         recv_stall_pct = stall[ph];
         repeat (NUM_RANDOM / 4) random_item();
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoff_left  <= 400;
      repeat (200) random_item();
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_backpressure();
      test_random_phases();
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
